// ===== sv/assert_macros.svh =====
// assertion macros for the checker module
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PITM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PITM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pitm_pkg.sv =====
// types and fixed constants for the triangle mesh point locator
// no dependencies
package pitm_pkg;

  // fixed field widths of the transaction ports
  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 10;
  localparam int COORD_IN_W = 32;
  localparam int CORNER_W   = 10;
  localparam int COUNT_W    = 11;
  localparam int INDEX_W    = 10;
  localparam int TRI_W      = 3 * CORNER_W;
  // wide enough for any index or count the parameters allow
  localparam int EXT_W      = 17;

  // transaction kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_QUERY    = 2'd2
  } kind_t;

  // control states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage

// ===== sv/pitm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module pitm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/point_in_triangle_mesh_locate_top.sv =====
// triangle mesh point locator: vertex and triangle stores and the scan pipeline
// depends on pitm_pkg and pitm_ram
//
// Write transactions (vertex or triangle) leave busy low. A query walks triangles 0 to
// count-1, count capped at MAX_TRIANGLES, one triangle per cycle, through a five stage
// pipeline: triangle memory read, corner vertex reads (three vertex memory copies),
// edge differences, edge products, sign test. The scan ends at the first hit or after
// the last triangle and the result is registered; a count of zero answers in the next
// cycle. busy stays high while a query runs.
// out_valid is high for one cycle and cannot be held off by the receiver.
module point_in_triangle_mesh_locate_top #(
  parameter int MAX_VERTICES  = 1024,
  parameter int MAX_TRIANGLES = 1024,
  parameter int COORD_BITS    = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // query and write transactions
  input  logic                              start,
  output logic                              busy,
  input  logic [pitm_pkg::KIND_W-1:0]       in_kind,
  input  logic [pitm_pkg::SLOT_W-1:0]       in_slot,
  input  logic signed [pitm_pkg::COORD_IN_W-1:0] in_coord_x,
  input  logic signed [pitm_pkg::COORD_IN_W-1:0] in_coord_y,
  input  logic [pitm_pkg::CORNER_W-1:0]     in_corner_a,
  input  logic [pitm_pkg::CORNER_W-1:0]     in_corner_b,
  input  logic [pitm_pkg::CORNER_W-1:0]     in_corner_c,
  // results
  output logic                              out_valid,
  output logic                              out_found,
  output logic [pitm_pkg::INDEX_W-1:0]      out_triangle_index,
  // triangle count register
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pitm_pkg::COUNT_W-1:0]      cfg_triangle_count
);

  import pitm_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int DW    = CB + 1;
  localparam int PW    = 2 * DW;
  localparam int VA_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int TA_W  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
  localparam logic [EXT_W-1:0] MAXV_EXT = EXT_W'(MAX_VERTICES);
  localparam logic [EXT_W-1:0] MAXT_EXT = EXT_W'(MAX_TRIANGLES);

  // control and configuration registers
  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     t_r;
  logic [CB-1:0]        px_r, py_r;

  // pipeline valids and triangle indexes
  logic                 v1_r, v2_r, v3_r, v4_r;
  logic [CNT_W-1:0]     idx1_r, idx2_r, idx3_r, idx4_r;
  logic [2:0]           oor2_r;

  // result register
  logic                 out_valid_r, out_found_r;
  logic [INDEX_W-1:0]   out_index_r;

  // control decodes
  logic                 accept;
  logic                 wr_vertex, wr_triangle, query_go, query_empty;
  logic                 issue, finish, hit, last;
  logic [EXT_W-1:0]     slot_ext, count_ext, idx_ext;
  logic [CNT_W-1:0]     n_sat;

  // memory ports
  logic [2*CB-1:0]      vtx_rd [3];
  logic [TRI_W-1:0]     tri_rd;
  logic [CORNER_W-1:0]  corner [3];
  logic [VA_W-1:0]      vtx_raddr [3];
  logic [2:0]           corner_oor;

  // edge arithmetic
  logic signed [DW-1:0] vxe [3];
  logic signed [DW-1:0] vye [3];
  logic signed [DW-1:0] pxe, pye;
  logic signed [DW-1:0] dxk_nxt [3], dyp_nxt [3], dyk_nxt [3], dxp_nxt [3];
  logic signed [DW-1:0] dxk_r [3], dyp_r [3], dyk_r [3], dxp_r [3];
  logic signed [PW-1:0] p_r [3], q_r [3];
  logic signed [PW:0]   z [3];
  logic [2:0]           neg;

  // transaction decode
  assign accept    = start && !busy;
  assign slot_ext  = EXT_W'(in_slot);
  assign count_ext = EXT_W'(count_r);
  assign n_sat     = (count_ext > MAXT_EXT) ? MAXT_EXT[CNT_W-1:0] : count_ext[CNT_W-1:0];

  always_comb begin
    wr_vertex   = 1'b0;
    wr_triangle = 1'b0;
    query_go    = 1'b0;
    query_empty = 1'b0;
    unique case (in_kind)
      KIND_VERTEX: begin
        wr_vertex = accept && (slot_ext < MAXV_EXT);
      end
      KIND_TRIANGLE: begin
        wr_triangle = accept && (slot_ext < MAXT_EXT);
      end
      KIND_QUERY: begin
        query_go    = accept && (n_sat != '0);
        query_empty = accept && (n_sat == '0);
      end
      default: begin
      end
    endcase
  end

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_triangle_count;
    end
  end

  // vertex store, one copy per corner so all three read in the same cycle
  for (genvar g = 0; g < 3; g++) begin : g_vtx
    pitm_ram #(
      .WIDTH (2 * CB),
      .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
      .clk   (clk),
      .we    (wr_vertex),
      .waddr (slot_ext[VA_W-1:0]),
      .wdata ({in_coord_y[CB-1:0], in_coord_x[CB-1:0]}),
      .raddr (vtx_raddr[g]),
      .rdata (vtx_rd[g])
    );
  end

  // triangle store
  pitm_ram #(
    .WIDTH (TRI_W),
    .DEPTH (MAX_TRIANGLES)
  ) u_tri_ram (
    .clk   (clk),
    .we    (wr_triangle),
    .waddr (slot_ext[TA_W-1:0]),
    .wdata ({in_corner_c, in_corner_b, in_corner_a}),
    .raddr (t_r[TA_W-1:0]),
    .rdata (tri_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (query_go) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy   = 1'b0;
    issue  = 1'b0;
    finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_SCAN: begin
        busy   = 1'b1;
        issue  = (t_r < n_r);
        finish = v4_r && (hit || last);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // query setup and issue counter
  always_ff @(posedge clk) begin
    if (query_go) begin
      n_r  <= n_sat;
      t_r  <= '0;
      px_r <= in_coord_x[CB-1:0];
      py_r <= in_coord_y[CB-1:0];
    end else if (issue) begin
      t_r  <= t_r + 1'b1;
    end
  end

  // stage 1: corner indexes from the triangle store
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      corner[l]     = tri_rd[l*CORNER_W +: CORNER_W];
      corner_oor[l] = EXT_W'(corner[l]) >= MAXV_EXT;
      vtx_raddr[l]  = VA_W'(EXT_W'(corner[l]));
    end
  end

  // stage 2: corner coordinates, then edge differences
  assign pxe = {px_r[CB-1], px_r};
  assign pye = {py_r[CB-1], py_r};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (oor2_r[l]) begin
        vxe[l] = '0;
        vye[l] = '0;
      end else begin
        vxe[l] = {vtx_rd[l][CB-1], vtx_rd[l][CB-1:0]};
        vye[l] = {vtx_rd[l][2*CB-1], vtx_rd[l][2*CB-1:CB]};
      end
    end
    for (int l = 0; l < 3; l++) begin
      dxk_nxt[l] = vxe[(l + 1) % 3] - vxe[l];
      dyk_nxt[l] = vye[(l + 1) % 3] - vye[l];
      dyp_nxt[l] = pye - vye[l];
      dxp_nxt[l] = pxe - vxe[l];
    end
  end

  // stage 3 and 4 registers: differences, then products
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      dxk_r[l] <= dxk_nxt[l];
      dyk_r[l] <= dyk_nxt[l];
      dyp_r[l] <= dyp_nxt[l];
      dxp_r[l] <= dxp_nxt[l];
      p_r[l]   <= PW'(dxk_r[l]) * PW'(dyp_r[l]);
      q_r[l]   <= PW'(dyk_r[l]) * PW'(dxp_r[l]);
    end
  end

  // stage 5: sign of each edge function
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      z[l]   = {p_r[l][PW-1], p_r[l]} - {q_r[l][PW-1], q_r[l]};
      neg[l] = z[l][PW];
    end
  end

  assign hit  = (neg == 3'b000);
  assign last = (CNT_W'(idx4_r + 1'b1) == n_r);

  // pipeline valids, flushed when the scan ends
  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= t_r;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    oor2_r <= corner_oor;
  end

  // result register
  assign idx_ext = EXT_W'(idx4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= finish || query_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && hit) begin
      out_found_r <= 1'b1;
      out_index_r <= idx_ext[INDEX_W-1:0];
    end else begin
      out_found_r <= 1'b0;
      out_index_r <= '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_triangle_index = out_index_r;

endmodule

// ===== sv/pitm_checker.sv =====
// port-level checks for the triangle mesh point locator, bound to the top level
// depends on pitm_pkg and assert_macros.svh
`include "assert_macros.svh"

module pitm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [pitm_pkg::KIND_W-1:0]  in_kind,
  input logic                         out_valid,
  input logic                         out_found,
  input logic [pitm_pkg::INDEX_W-1:0] out_triangle_index
);

  import pitm_pkg::*;

  // a miss always reports index zero
  `PITM_ASSERT_SAME(a_miss_index_zero, out_valid && !out_found, out_triangle_index == '0, "miss with nonzero index")

  // no result while a query is still scanning
  `PITM_ASSERT_SAME(a_no_result_busy, out_valid, !busy, "result while busy")

  // a finished scan always delivers its result
  `PITM_ASSERT_SAME(a_scan_ends_result, $fell(busy) && $past(rst_n), out_valid, "scan ended without result")

  // write and reserved-kind transactions produce no result
  `PITM_ASSERT_NEXT(a_write_no_result, start && !busy && in_kind != KIND_QUERY, !out_valid, "result from write")

endmodule

bind point_in_triangle_mesh_locate_top pitm_checker u_pitm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_kind            (in_kind),
  .out_valid          (out_valid),
  .out_found          (out_found),
  .out_triangle_index (out_triangle_index)
);

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for point_in_triangle_mesh_locate_top
// depends on pitm_pkg and the locator RTL; keeps its own mesh copy to predict each answer
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pitm_pkg::*;

  localparam int MESH_DEPTH = 1024;
  // triangles 0 to FILL_DEPTH-1 are written; the two at COVER_SLOT cover the plane
  localparam int FILL_DEPTH = 136;
  localparam int COVER_SLOT = 126;
  localparam int RANDOM_ITEMS = 400;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;

  typedef struct packed {
    logic [CORNER_W-1:0] a;
    logic [CORNER_W-1:0] b;
    logic [CORNER_W-1:0] c;
  } tri_t;

  typedef struct {
    logic [KIND_W-1:0]     kind;
    logic [SLOT_W-1:0]     slot;
    logic signed [31:0]    x;
    logic signed [31:0]    y;
    tri_t                  corners;
  } mesh_cmd_t;

  typedef struct {
    logic               found;
    logic [INDEX_W-1:0] index;
  } location_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] in_kind = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic signed [COORD_IN_W-1:0] in_coord_x = '0;
  logic signed [COORD_IN_W-1:0] in_coord_y = '0;
  logic [CORNER_W-1:0] in_corner_a = '0;
  logic [CORNER_W-1:0] in_corner_b = '0;
  logic [CORNER_W-1:0] in_corner_c = '0;
  logic out_valid;
  logic out_found;
  logic [INDEX_W-1:0] out_triangle_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_triangle_count = '0;

  // mirror of the block state
  logic signed [31:0] mesh_vx [MESH_DEPTH];
  logic signed [31:0] mesh_vy [MESH_DEPTH];
  tri_t               mesh_tri [MESH_DEPTH];
  bit                 vertex_seen [MESH_DEPTH];
  int                 vertex_slots [$];
  logic [COUNT_W-1:0] mesh_count = '0;

  location_t expected_locations [$];
  location_t front_location;
  int        mismatch_count = 0;
  bit        steady = 1'b0;

  always #5 clk = ~clk;

  point_in_triangle_mesh_locate_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_slot            (in_slot),
    .in_coord_x         (in_coord_x),
    .in_coord_y         (in_coord_y),
    .in_corner_a        (in_corner_a),
    .in_corner_b        (in_corner_b),
    .in_corner_c        (in_corner_c),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_triangle_index (out_triangle_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_triangle_count (cfg_triangle_count)
  );

  // sign of the exact edge cross product, point p against edge l -> k
  function automatic bit edge_negative(input logic signed [31:0] xl, yl, xk, yk, px, py);
    logic signed [71:0] dxe, dye, dxp, dyp, z;
    dxe = xk - xl;
    dye = yk - yl;
    dxp = px - xl;
    dyp = py - yl;
    z = dxe * dyp - dye * dxp;
    return z[71];
  endfunction

  // first triangle of the searched range that holds the point
  function automatic location_t locate_point(input logic signed [31:0] px, py);
    location_t r;
    int n;
    int k;
    bit hit;
    logic [CORNER_W-1:0] idx [3];
    r.found = 1'b0;
    r.index = '0;
    n = (mesh_count > MESH_DEPTH) ? MESH_DEPTH : int'(mesh_count);
    for (int t = 0; t < n; t++) begin
      idx[0] = mesh_tri[t].a;
      idx[1] = mesh_tri[t].b;
      idx[2] = mesh_tri[t].c;
      hit = 1'b1;
      for (int l = 0; l < 3; l++) begin
        k = (l == 2) ? 0 : l + 1;
        if (edge_negative(mesh_vx[idx[l]], mesh_vy[idx[l]], mesh_vx[idx[k]],
                          mesh_vy[idx[k]], px, py))
          hit = 1'b0;
      end
      if (hit) begin
        r.found = 1'b1;
        r.index = 10'(t);
        return r;
      end
    end
    return r;
  endfunction

  // mostly small coordinates, some full range, some extremes
  function automatic logic signed [31:0] rand_coord();
    int r;
    logic signed [31:0] picks [4];
    picks = '{CMAX, CMIN, 32'sd0, -32'sd1};
    r = $urandom_range(0, 99);
    if (r < 70)
      return int'($urandom_range(0, 2 << 18)) - (1 << 18);
    else if (r < 90)
      return $urandom;
    return picks[$urandom_range(0, 3)];
  endfunction

  // drive one transaction, wait for it to be taken, update the mirror
  task automatic send_cmd(input mesh_cmd_t c);
    start       <= 1'b1;
    in_kind     <= c.kind;
    in_slot     <= c.slot;
    in_coord_x  <= c.x;
    in_coord_y  <= c.y;
    in_corner_a <= c.corners.a;
    in_corner_b <= c.corners.b;
    in_corner_c <= c.corners.c;
    do @(posedge clk); while (busy);
    case (c.kind)
      KIND_VERTEX: begin
        mesh_vx[c.slot] = c.x;
        mesh_vy[c.slot] = c.y;
        if (!vertex_seen[c.slot]) begin
          vertex_seen[c.slot] = 1'b1;
          vertex_slots.push_back(c.slot);
        end
      end
      KIND_TRIANGLE: mesh_tri[c.slot] = c.corners;
      KIND_QUERY:    expected_locations.push_back(locate_point(c.x, c.y));
      default: ;
    endcase
    if (!steady && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_vertex(input int slot, input logic signed [31:0] x, y);
    mesh_cmd_t c;
    c = '{KIND_VERTEX, 10'(slot), x, y, '0};
    send_cmd(c);
  endtask

  task automatic send_triangle(input int slot, input int a, b, cc);
    mesh_cmd_t c;
    c = '{KIND_TRIANGLE, 10'(slot), $urandom, $urandom, {10'(a), 10'(b), 10'(cc)}};
    send_cmd(c);
  endtask

  task automatic send_query(input logic signed [31:0] x, y);
    mesh_cmd_t c;
    c = '{KIND_QUERY, 10'($urandom), x, y, tri_t'($urandom)};
    send_cmd(c);
  endtask

  // let all queries finish and the pipeline empty out
  task automatic settle_mesh();
    start <= 1'b0;
    while (expected_locations.size() > 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // triangle count register write, only with the block idle
  task automatic write_count(input logic [COUNT_W-1:0] v);
    settle_mesh();
    if ($urandom_range(0, 99) < 34) repeat ($urandom_range(1, 4)) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_triangle_count <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    mesh_count = v;
  endtask

  // count from reset is zero: every query misses; reserved kind is dropped
  task automatic test_empty_mesh();
    mesh_cmd_t c;
    send_query(ONE, ONE);
    c = '{KIND_RESERVED, 10'h3FF, CMAX, CMIN, '1};
    send_cmd(c);
    send_query(CMIN, CMAX);
  endtask

  // hand-built shapes: clockwise, counter-clockwise, full-range and degenerate
  task automatic test_basic_shapes();
    send_vertex(0, 0, 0);
    send_vertex(1, 4 * ONE, 0);
    send_vertex(2, 0, 4 * ONE);
    send_vertex(3, 8 * ONE, 8 * ONE);
    send_vertex(1023, CMIN, CMIN);
    send_vertex(512, CMAX, CMIN);
    send_vertex(513, CMIN, CMAX);
    send_triangle(0, 0, 2, 1);
    send_triangle(1, 0, 1, 2);
    send_triangle(2, 1023, 512, 513);
    send_triangle(3, 0, 3, 0);
    write_count(4);
    // inside, on an edge, on a corner, outside
    send_query(ONE, ONE);
    send_query(2 * ONE, 2 * ONE);
    send_query(0, 0);
    send_query(-ONE, -ONE);
    // on the degenerate line only
    send_query(7 * ONE, 7 * ONE);
    send_query(CMAX, CMAX);
    send_query(CMAX, CMIN);
    send_query(CMIN, CMIN);
    send_query(CMIN, CMAX);
    // only the clockwise triangle is searched
    write_count(1);
    send_query(ONE, ONE);
    send_query(0, 0);
  endtask

  // fill the low triangle entries; two of them cover the whole plane so that
  // large counts always stop there, then search with counts up to and beyond the store
  task automatic test_full_mesh();
    send_vertex(1022, CMAX, CMAX);
    repeat (12) send_vertex($urandom_range(4, 511), rand_coord(), rand_coord());
    for (int t = 4; t < FILL_DEPTH; t++)
      send_triangle(t, vertex_slots[$urandom_range(0, vertex_slots.size() - 1)],
                    vertex_slots[$urandom_range(0, vertex_slots.size() - 1)],
                    vertex_slots[$urandom_range(0, vertex_slots.size() - 1)]);
    // lower-left and upper-right halves of the coordinate square
    send_triangle(COVER_SLOT, 1023, 512, 513);
    send_triangle(COVER_SLOT + 1, 512, 1022, 513);
    write_count(11'd1024);
    send_query(CMAX, CMAX - 1);
    send_query(rand_coord(), rand_coord());
    write_count(11'd2047);
    send_query(CMAX, CMAX - 1);
    send_query(ONE, 3 * ONE);
    write_count(11'd1023);
    send_query(CMAX, CMAX - 1);
  endtask

  // one random transaction; mostly queries aimed at searched triangles
  task automatic random_item(output bit counted);
    mesh_cmd_t c;
    int r;
    int n;
    tri_t t;
    logic signed [31:0] ax, ay, bx, by, cx, cy;
    longint sx, sy;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 55) begin
      n = (mesh_count == 0 || mesh_count > FILL_DEPTH) ? FILL_DEPTH : int'(mesh_count);
      t = mesh_tri[$urandom_range(0, n - 1)];
      ax = mesh_vx[t.a]; ay = mesh_vy[t.a];
      bx = mesh_vx[t.b]; by = mesh_vy[t.b];
      cx = mesh_vx[t.c]; cy = mesh_vy[t.c];
      case ($urandom_range(0, 3))
        0: begin
          sx = (longint'(ax) + bx + cx) / 3;
          sy = (longint'(ay) + by + cy) / 3;
        end
        1: begin
          sx = (longint'(ax) + bx) / 2;
          sy = (longint'(ay) + by) / 2;
        end
        2: begin
          sx = cx;
          sy = cy;
        end
        default: begin
          sx = rand_coord();
          sy = rand_coord();
        end
      endcase
      c = '{KIND_QUERY, 10'($urandom), 32'(sx), 32'(sy), tri_t'($urandom)};
    end else if (r < 80) begin
      // covering triangles keep their corners
      c = '{KIND_VERTEX, 10'($urandom_range(0, 511)), rand_coord(), rand_coord(),
            tri_t'($urandom)};
    end else if (r < 95) begin
      t.a = vertex_slots[$urandom_range(0, vertex_slots.size() - 1)];
      t.b = vertex_slots[$urandom_range(0, vertex_slots.size() - 1)];
      t.c = vertex_slots[$urandom_range(0, vertex_slots.size() - 1)];
      c = '{KIND_TRIANGLE, 10'($urandom_range(0, COVER_SLOT - 1)), $urandom, $urandom, t};
    end else begin
      c = '{KIND_RESERVED, 10'($urandom), $urandom, $urandom, tri_t'($urandom)};
      counted = 1'b0;
    end
    send_cmd(c);
  endtask

  // random phases, each with its own triangle count
  task automatic test_random_traffic();
    int sent;
    int phase;
    int r;
    bit counted;
    logic [COUNT_W-1:0] cnt;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80)      cnt = $urandom_range(0, 24);
      else if (r < 88) cnt = $urandom_range(25, 200);
      else if (r < 94) cnt = 11'd1024;
      else             cnt = $urandom_range(1025, 2047);
      write_count(cnt);
      // one phase runs back to back
      steady = (phase == 2);
      repeat ($urandom_range(25, 50)) begin
        random_item(counted);
        if (counted) sent++;
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // compare each result with the oldest waiting prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_locations.size() == 0) begin
        $display("%0t: unexpected result found=%0b index=%0d", $time, out_found,
                 out_triangle_index);
        mismatch_count++;
      end else begin
        front_location = expected_locations.pop_front();
        if (out_found !== front_location.found) begin
          $display("%0t: found expected %0b actual %0b", $time, front_location.found,
                   out_found);
          mismatch_count++;
        end
        if (out_triangle_index !== front_location.index) begin
          $display("%0t: triangle_index expected %0d actual %0d", $time,
                   front_location.index, out_triangle_index);
          mismatch_count++;
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_mesh();
    test_basic_shapes();
    test_full_mesh();
    test_random_traffic();
    settle_mesh();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_locations.size() == 0) begin
      $display("point_in_triangle_mesh_locate_top: match");
    end else begin
      $display("point_in_triangle_mesh_locate_top: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #80_000_000;
    $display("point_in_triangle_mesh_locate_top: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pitm_pkg.sv
sv/pitm_ram.sv
sv/point_in_triangle_mesh_locate_top.sv
sv/pitm_checker.sv
tb/sv/tb_top.sv
